FILE: rtl/core/hrsp_pkg.sv
// ----------------------------------------------------------------------------
// hrsp_pkg
// Types, character codes and the hex digit decoder for the HEX record parser.
// ----------------------------------------------------------------------------
package hrsp_pkg;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_F = 8'h46;

  localparam logic [7:0] REC_DATA     = 8'h00;
  localparam logic [7:0] REC_EXT_ADDR = 8'h04;

  localparam int HEADER_DIGITS = 8;
  localparam int SUM_DIGITS    = 2;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_HEAD,
    PH_DATA,
    PH_SUM
  } phase_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] nib;
  } hex_digit_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] byte_address;
    logic [7:0]  data_byte;
    logic        bad_char;
  } result_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t d;
    logic [7:0] diff;
    d = '0;
    diff = '0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      diff = c - CHAR_ZERO;
      d.ok = 1'b1;
      d.nib = diff[3:0];
    end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
      diff = c - CHAR_UPPER_A + 8'd10;
      d.ok = 1'b1;
      d.nib = diff[3:0];
    end
    return d;
  endfunction

endpackage

FILE: rtl/core/hex_record_stream_parser_core.sv
// ----------------------------------------------------------------------------
// hex_record_stream_parser_core
// Intel HEX text to addressed data bytes, one character per word.
// ----------------------------------------------------------------------------
// Takes one ASCII character per cycle and answers each data byte of a type 00
// record with its 32-bit address (upper base from type 04 records plus record
// offset plus byte index), or flags a non-hex character in header or data.
// Each character is decoded in the cycle it is accepted; a result appears on
// the output register the following cycle. The output register is the only
// stall point: input is taken whenever that register is empty or being read.
module hex_record_stream_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] text_char
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] byte_address, [39:32] data_byte
  output logic        m_tuser    // [0] bad_char
);

  hrsp_pkg::result_t res;
  logic take;

  assign s_tready = !m_tvalid || m_tready;
  assign take = s_tvalid && s_tready;

  hrsp_decoder u_decoder (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .text_char (s_tdata),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= res.valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res.valid) begin
      m_tdata <= {res.data_byte, res.byte_address};
      m_tuser <= res.bad_char;
    end
  end

endmodule

FILE: rtl/core/hrsp_decoder.sv
// ----------------------------------------------------------------------------
// hrsp_decoder
// Record state machine: header decode, address tracking and byte results.
// ----------------------------------------------------------------------------
module hrsp_decoder (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [7:0]        text_char,
  output hrsp_pkg::result_t res
);

  hrsp_pkg::phase_t phase, phase_next;
  logic [8:0]  digit_count, digit_count_next;
  logic [3:0]  high_nibble, high_nibble_next;
  logic [7:0]  record_length, record_length_next;
  logic [15:0] record_offset, record_offset_next;
  logic [7:0]  record_type, record_type_next;
  logic [15:0] upper_address, upper_address_next;
  logic [7:0]  byte_index, byte_index_next;

  hrsp_pkg::hex_digit_t dig;
  logic [8:0] dc_inc;
  logic [7:0] byte_val;
  logic [7:0] type_eff;
  logic       odd;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= hrsp_pkg::PH_HUNT;
      digit_count <= '0;
      high_nibble <= '0;
      record_length <= '0;
      record_offset <= '0;
      record_type <= '0;
      upper_address <= '0;
      byte_index <= '0;
    end else begin
      phase <= phase_next;
      digit_count <= digit_count_next;
      high_nibble <= high_nibble_next;
      record_length <= record_length_next;
      record_offset <= record_offset_next;
      record_type <= record_type_next;
      upper_address <= upper_address_next;
      byte_index <= byte_index_next;
    end
  end

  always_comb begin
    dig = hrsp_pkg::hex_decode(text_char);
    dc_inc = digit_count + 9'd1;
    odd = digit_count[0];
    byte_val = {high_nibble, dig.nib};
    type_eff = (odd && digit_count[2:1] == 2'd3) ? byte_val : record_type;

    phase_next = phase;
    digit_count_next = digit_count;
    high_nibble_next = high_nibble;
    record_length_next = record_length;
    record_offset_next = record_offset;
    record_type_next = record_type;
    upper_address_next = upper_address;
    byte_index_next = byte_index;
    res = '0;

    if (take) begin
      unique case (phase)
        hrsp_pkg::PH_SUM: begin
          if (dc_inc >= 9'(hrsp_pkg::SUM_DIGITS)) begin
            phase_next = hrsp_pkg::PH_HUNT;
            digit_count_next = '0;
          end else begin
            digit_count_next = dc_inc;
          end
        end
        hrsp_pkg::PH_HEAD, hrsp_pkg::PH_DATA: begin
          if (!dig.ok) begin
            phase_next = hrsp_pkg::PH_HUNT;
            digit_count_next = '0;
            res.valid = 1'b1;
            res.bad_char = 1'b1;
          end else begin
            if (!odd) begin
              high_nibble_next = dig.nib;
            end
            digit_count_next = dc_inc;
            if (phase == hrsp_pkg::PH_HEAD) begin
              if (odd) begin
                unique case (digit_count[2:1])
                  2'd0: record_length_next = byte_val;
                  2'd1: record_offset_next[15:8] = byte_val;
                  2'd2: record_offset_next[7:0] = byte_val;
                  default: record_type_next = byte_val;
                endcase
              end
              if (dc_inc >= 9'(hrsp_pkg::HEADER_DIGITS)) begin
                digit_count_next = '0;
                byte_index_next = '0;
                if (type_eff == hrsp_pkg::REC_EXT_ADDR) begin
                  upper_address_next = '0;
                end
                phase_next = (record_length == 8'd0) ? hrsp_pkg::PH_SUM : hrsp_pkg::PH_DATA;
              end
            end else begin
              if (record_type == hrsp_pkg::REC_EXT_ADDR && digit_count < 9'd4) begin
                unique case (digit_count[1:0])
                  2'd0: upper_address_next[15:12] = dig.nib;
                  2'd1: upper_address_next[11:8] = dig.nib;
                  2'd2: upper_address_next[7:4] = dig.nib;
                  default: upper_address_next[3:0] = dig.nib;
                endcase
              end
              if (odd) begin
                if (record_type == hrsp_pkg::REC_DATA) begin
                  res.valid = 1'b1;
                  res.byte_address = {upper_address, 16'h0000} + {16'h0000, record_offset}
                                     + {24'h000000, byte_index};
                  res.data_byte = byte_val;
                end
                byte_index_next = byte_index + 8'd1;
              end
              if (dc_inc >= {record_length, 1'b0}) begin
                digit_count_next = '0;
                phase_next = hrsp_pkg::PH_SUM;
              end
            end
          end
        end
        default: begin
          phase_next = hrsp_pkg::PH_HUNT;
          if (text_char == hrsp_pkg::CHAR_COLON) begin
            phase_next = hrsp_pkg::PH_HEAD;
            digit_count_next = '0;
          end
        end
      endcase
    end
  end

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the HEX record stream parser core.
// ----------------------------------------------------------------------------
// Feeds Intel HEX text one character per word: a directed opening, then
// mostly well-formed random records with broken ones and noise mixed in.
// A local parser tracks every accepted character and queues the data bytes
// and bad-character flags it predicts. Each output word is checked against
// the oldest queued byte. Both sides idle at random, and the output side
// holds off for long stretches.
// ----------------------------------------------------------------------------
module tb;
  import hrsp_pkg::*;

  localparam int          RUN_LIMIT    = 400000;
  localparam int          TARGET_CHARS = 1600;
  localparam logic [7:0]  CHAR_LOWER_A = 8'h61;
  localparam logic [7:0]  CHAR_CR      = 8'h0D;
  localparam logic [7:0]  CHAR_LF      = 8'h0A;

  typedef struct packed {
    logic [31:0] addr;
    logic [7:0]  data;
    logic        bad;
  } parsed_t;

  typedef struct {
    logic [7:0] ch;
    bit         drain;
  } feed_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tuser;

  feed_t       feed_q[$];
  parsed_t     want_q[$];
  int unsigned fails = 0;
  int unsigned cycle = 0;
  int unsigned sent_chars = 0;
  bit          took_char = 1'b0;

  // local copy of the parser state
  phase_t      phase = PH_HUNT;
  int unsigned digits = 0;
  logic [3:0]  hi_nib = '0;
  logic [7:0]  rec_len = '0;
  logic [15:0] rec_off = '0;
  logic [7:0]  rec_type = '0;
  logic [15:0] upper = '0;
  logic [7:0]  idx = '0;

  hex_record_stream_parser_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic parse_char(input logic [7:0] c);
    parsed_t    r;
    logic [7:0] val;
    logic [7:0] pair;
    logic [3:0] nib;
    logic       ok;
    logic       odd;
    r = '0;
    val = '0;
    ok = 1'b1;
    case (phase)
      PH_SUM: begin
        digits++;
        if (digits >= SUM_DIGITS) begin
          phase = PH_HUNT;
          digits = 0;
        end
      end
      PH_HUNT: begin
        if (c == CHAR_COLON) begin
          phase = PH_HEAD;
          digits = 0;
        end
      end
      default: begin
        if (c >= CHAR_ZERO && c <= CHAR_NINE) val = c - CHAR_ZERO;
        else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) val = c - CHAR_UPPER_A + 8'd10;
        else ok = 1'b0;
        nib = val[3:0];
        if (!ok) begin
          phase = PH_HUNT;
          digits = 0;
          r.bad = 1'b1;
          want_q.push_back(r);
        end else begin
          odd = digits[0];
          pair = {hi_nib, nib};
          if (!odd) hi_nib = nib;
          if (phase == PH_HEAD) begin
            if (odd) begin
              case (digits >> 1)
                0: rec_len = pair;
                1: rec_off[15:8] = pair;
                2: rec_off[7:0] = pair;
                default: rec_type = pair;
              endcase
            end
            digits++;
            if (digits >= HEADER_DIGITS) begin
              digits = 0;
              idx = '0;
              if (rec_type == REC_EXT_ADDR) upper = '0;
              phase = (rec_len == 0) ? PH_SUM : PH_DATA;
            end
          end else begin
            if (rec_type == REC_EXT_ADDR && digits < 4) upper[4 * (3 - digits) +: 4] = nib;
            if (odd) begin
              if (rec_type == REC_DATA) begin
                r.addr = {upper, 16'h0000} + {16'h0000, rec_off} + {24'h000000, idx};
                r.data = pair;
                want_q.push_back(r);
              end
              idx++;
            end
            digits++;
            if (digits >= 2 * rec_len) begin
              digits = 0;
              phase = PH_SUM;
            end
          end
        end
      end
    endcase
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? CHAR_ZERO + {4'h0, n} : CHAR_UPPER_A + {4'h0, n} - 8'd10;
  endfunction

  task automatic push_char(input logic [7:0] c);
    feed_t f;
    f.ch = c;
    f.drain = 1'b0;
    feed_q.push_back(f);
  endtask

  task automatic push_drain();
    feed_t f;
    f.ch = '0;
    f.drain = 1'b1;
    feed_q.push_back(f);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  task automatic gen_record();
    logic [7:0]  rec[$];
    logic [7:0]  len;
    logic [7:0]  kind;
    logic [7:0]  b;
    logic [7:0]  c;
    logic [15:0] off;
    logic [15:0] up;
    int          pick;
    int          cut;
    pick = $urandom_range(0, 99);
    if (pick < 55) kind = REC_DATA;
    else if (pick < 75) kind = REC_EXT_ADDR;
    else kind = 8'($urandom_range(0, 255));
    if (kind == REC_EXT_ADDR) len = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 4)) : 8'd2;
    else if ($urandom_range(0, 59) == 0) len = 8'($urandom_range(32, 255));
    else len = 8'($urandom_range(0, 12));
    off = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(16'hFFF0, 16'hFFFF))
                                      : 16'($urandom);
    case ($urandom_range(0, 2))
      0: up = 16'h0000;
      1: up = 16'hFFFF;
      default: up = 16'($urandom);
    endcase
    rec.push_back(CHAR_COLON);
    for (int i = 0; i < 4 + len; i++) begin
      case (i)
        0: b = len;
        1: b = off[15:8];
        2: b = off[7:0];
        3: b = kind;
        default: begin
          if (kind == REC_EXT_ADDR && i < 6) b = (i == 4) ? up[15:8] : up[7:0];
          else b = 8'($urandom);
        end
      endcase
      rec.push_back(hex_char(b[7:4]));
      rec.push_back(hex_char(b[3:0]));
    end
    for (int i = 0; i < 2; i++) begin
      b = 8'($urandom);
      rec.push_back($urandom_range(0, 1) ? hex_char(b[3:0]) : b);
    end
    if ($urandom_range(0, 5) == 0) begin
      cut = $urandom_range(1, rec.size() - 3);
      case ($urandom_range(0, 3))
        0: c = CHAR_COLON;
        1: c = CHAR_LOWER_A + 8'($urandom_range(0, 5));
        default: begin
          do c = 8'($urandom);
          while ((c >= CHAR_ZERO && c <= CHAR_NINE) || (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F));
        end
      endcase
      rec[cut] = c;
      if ($urandom_range(0, 1)) rec = rec[0:cut];
    end
    case ($urandom_range(0, 3))
      0: ;
      1: begin
        rec.push_back(CHAR_CR);
        rec.push_back(CHAR_LF);
      end
      2: rec.push_back(CHAR_LF);
      default: begin
        for (int i = $urandom_range(1, 3); i > 0; i--) rec.push_back(8'($urandom));
      end
    endcase
    foreach (rec[i]) push_char(rec[i]);
    sent_chars += rec.size();
  endtask

  always @(negedge clk) begin : drive
    feed_t      f;
    logic       v;
    logic [7:0] d;
    int unsigned gap_left;
    int unsigned burst_left;
    int         r;
    v = s_tvalid;
    d = s_tdata;
    if (rst) begin
      v = 1'b0;
    end else if (!s_tvalid || took_char) begin
      v = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (feed_q.size() > 0) begin
        if (feed_q[0].drain) begin
          if (want_q.size() == 0 && !m_tvalid) void'(feed_q.pop_front());
        end else begin
          f = feed_q.pop_front();
          v = 1'b1;
          d = f.ch;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            r = $urandom_range(0, 9);
            if (r < 4) gap_left = 0;
            else if (r < 8) gap_left = $urandom_range(1, 3);
            else if (r < 9) gap_left = $urandom_range(4, 10);
            else gap_left = $urandom_range(20, 40);
          end
        end
      end
    end
    s_tvalid <= v;
    s_tdata <= d;
  end

  always @(negedge clk) begin : receive
    logic        rdy;
    int unsigned rx_cycles;
    int unsigned hold_left;
    int unsigned rx_mode;
    rx_cycles++;
    if (rx_cycles % 256 == 0) rx_mode = $urandom_range(0, 3);
    if (rx_cycles == 600 || rx_cycles == 1500) hold_left = 150;
    if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else begin
      case (rx_mode)
        0: rdy = 1'b1;
        1: rdy = ($urandom_range(0, 3) != 0);
        2: rdy = ($urandom_range(0, 3) == 0);
        default: rdy = (rx_cycles % 5 < 3);
      endcase
    end
    m_tready <= rdy;
  end

  always @(posedge clk) begin : observe
    parsed_t got;
    parsed_t exp;
    cycle++;
    if (cycle == RUN_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      took_char = 1'b0;
      if (!rst) begin
        if (m_tvalid && m_tready) begin
          got.addr = m_tdata[31:0];
          got.data = m_tdata[39:32];
          got.bad = m_tuser;
          if (want_q.size() == 0) begin
            $error("unexpected word: byte_address %h data_byte %h bad_char %b",
                   got.addr, got.data, got.bad);
            fails++;
          end else begin
            exp = want_q.pop_front();
            if (got.addr !== exp.addr) begin
              $error("byte_address: expected %h, got %h", exp.addr, got.addr);
              fails++;
            end
            if (got.data !== exp.data) begin
              $error("data_byte: expected %h, got %h", exp.data, got.data);
              fails++;
            end
            if (got.bad !== exp.bad) begin
              $error("bad_char: expected %b, got %b", exp.bad, got.bad);
              fails++;
            end
          end
        end
        if (s_tvalid && s_tready) begin
          took_char = 1'b1;
          parse_char(s_tdata);
        end
      end
    end
  end

  initial begin
    int unsigned next_drain;
    push_char(8'h00);
    push_char(8'hFF);
    push_text(":01000004F1ZZ");
    push_text(":01FFFF00AB\r\n");
    push_text(":0a");
    push_text(":1:");
    push_text(":00000001FF");
    push_drain();
    next_drain = 400;
    while (sent_chars < TARGET_CHARS) begin
      gen_record();
      if (sent_chars >= next_drain) begin
        push_drain();
        next_drain += 400;
      end
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    @(posedge clk);
    while (feed_q.size() != 0 || s_tvalid) @(posedge clk);
    while (want_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (want_q.size() != 0 || m_tvalid) begin
      $error("words left over at end: %0d expected, output valid %b", want_q.size(), m_tvalid);
      fails++;
    end
    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: hex_record_stream_parser_core.f
rtl/core/hrsp_pkg.sv
rtl/core/hrsp_decoder.sv
rtl/core/hex_record_stream_parser_core.sv
test/tb.sv
